>>> rtl/core/spmq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spmq_pkg
// Shared codes, widths and the controller command bundle for the
// strict priority multi queue.
// ----------------------------------------------------------------------------
package spmq_pkg;

  localparam int MODE_W   = 2;
  localparam int REQ_W    = 4;
  localparam int TASK_W   = 16;
  localparam int LEN_W    = 5;
  localparam int STATUS_W = 2;
  localparam int ACTIVE_W = 4;

  localparam logic [MODE_W-1:0] MODE_PUSH  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_POP   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BAD   = 2'd3;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 4'd8;

  // Controller to datapath commands, at most one high per cycle.
  typedef struct packed {
    logic capture;  // latch the incoming item
    logic execute;  // apply push or pop to the queue state
    logic lookup;   // pick the top level and read its head entry
    logic load;     // move the finished result into the output register
  } spmq_cmd_t;

endpackage

>>> rtl/core/strict_priority_multi_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strict_priority_multi_queue
// Strict priority queue of task handles, one FIFO per priority level.
// ----------------------------------------------------------------------------
// Each item is a push (append in_task_id to level in_priority_req), a pop
// (drop the head of the most urgent non-empty active level, level 1 first) or a
// query, and returns one result: the head task of the most urgent non-empty
// active level (0 when nothing is held), the valid/empty flags, the length
// of the named level and a status code. An item goes from transfer to result
// through capture, queue update, head read and result load. The head read
// goes through the task store's registered read port after the update has
// settled. A new item is taken in the cycle after the previous result was
// loaded, and none while one is in flight. A result waiting in the output
// register does not block acceptance of the next item; it only holds that
// item at its load step until the waiting result transfers.
// active_levels is written through cfg_wr_en/cfg_wr_data and must only be
// changed while no item is in flight.
// ----------------------------------------------------------------------------
module strict_priority_multi_queue
  import spmq_pkg::*;
#(
  parameter int NUM_LEVELS  = 8,
  parameter int LEVEL_DEPTH = 16,
  parameter int TASK_BITS   = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  // configuration
  input  logic                cfg_wr_en,
  input  logic [ACTIVE_W-1:0] cfg_wr_data,
  // item input
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [MODE_W-1:0]   in_mode,
  input  logic [REQ_W-1:0]    in_priority_req,
  input  logic [TASK_W-1:0]   in_task_id,
  // result output
  output logic                out_valid,
  input  logic                out_ready,
  output logic [TASK_W-1:0]   out_head_task,
  output logic                out_head_valid,
  output logic                out_all_empty,
  output logic [LEN_W-1:0]    out_level_length,
  output logic [STATUS_W-1:0] out_status
);

  spmq_cmd_t cmd;

  // Sequencer: one item in flight, output register decoupled from input.
  spmq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // Queue state, priority pick and task store.
  spmq_dp #(
    .NUM_LEVELS  (NUM_LEVELS),
    .LEVEL_DEPTH (LEVEL_DEPTH),
    .TASK_BITS   (TASK_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_mode          (in_mode),
    .in_priority_req  (in_priority_req),
    .in_task_id       (in_task_id),
    .out_head_task    (out_head_task),
    .out_head_valid   (out_head_valid),
    .out_all_empty    (out_all_empty),
    .out_level_length (out_level_length),
    .out_status       (out_status)
  );

endmodule

>>> rtl/core/spmq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spmq_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module spmq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/spmq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spmq_ctrl
// Sequencer for one item: capture, execute, lookup, result load.
// ----------------------------------------------------------------------------
module spmq_ctrl
  import spmq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output spmq_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LOOK,
    S_LOAD
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.execute = 1'b1;
        state_nxt   = S_LOOK;
      end
      S_LOOK: begin
        cmd.lookup = 1'b1;
        state_nxt  = S_LOAD;
      end
      S_LOAD: begin
        // hold until the previous result has been taken
        if (!out_valid_r || out_ready) begin
          cmd.load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second item taken while one is in flight");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !cmd.load)
    else $error("pending result overwritten");

  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == S_LOAD))
    else $error("result valid without a load");

endmodule

>>> rtl/core/spmq_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spmq_dp
// Queue state per level, priority pick, task store and result register.
// ----------------------------------------------------------------------------
module spmq_dp
  import spmq_pkg::*;
#(
  parameter int NUM_LEVELS  = 8,
  parameter int LEVEL_DEPTH = 16,
  parameter int TASK_BITS   = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  spmq_cmd_t           cmd,
  input  logic                cfg_wr_en,
  input  logic [ACTIVE_W-1:0] cfg_wr_data,
  input  logic [MODE_W-1:0]   in_mode,
  input  logic [REQ_W-1:0]    in_priority_req,
  input  logic [TASK_W-1:0]   in_task_id,
  output logic [TASK_W-1:0]   out_head_task,
  output logic                out_head_valid,
  output logic                out_all_empty,
  output logic [LEN_W-1:0]    out_level_length,
  output logic [STATUS_W-1:0] out_status
);

  localparam int LVL_W = $clog2(NUM_LEVELS);
  localparam int PTR_W = $clog2(LEVEL_DEPTH);
  localparam int CNT_W = $clog2(LEVEL_DEPTH + 1);
  localparam int MEM_D = NUM_LEVELS * LEVEL_DEPTH;
  localparam int ADR_W = $clog2(MEM_D);
  localparam int EFF_W = 6;

  logic [ACTIVE_W-1:0] active_r;
  logic [MODE_W-1:0]   mode_r;
  logic [REQ_W-1:0]    req_r;
  logic [TASK_BITS-1:0] task_r;

  logic [PTR_W-1:0] head_r  [NUM_LEVELS];
  logic [PTR_W-1:0] tail_r  [NUM_LEVELS];
  logic [CNT_W-1:0] count_r [NUM_LEVELS];
  logic [PTR_W-1:0] head_nxt  [NUM_LEVELS];
  logic [PTR_W-1:0] tail_nxt  [NUM_LEVELS];
  logic [CNT_W-1:0] count_nxt [NUM_LEVELS];

  logic [STATUS_W-1:0] status_r, status_nxt;
  logic                found_r;
  logic [LEN_W-1:0]    len_r;

  logic [TASK_W-1:0]   out_head_task_r;
  logic                out_head_valid_r;
  logic [LEN_W-1:0]    out_level_length_r;
  logic [STATUS_W-1:0] out_status_r;

  logic [EFF_W-1:0] eff;
  logic             level_ok;
  logic [LVL_W-1:0] lv;
  logic             found;
  logic [LVL_W-1:0] top;
  logic             lv_full;
  logic             push_ok;
  logic             pop_ok;

  logic                 ram_we;
  logic [ADR_W-1:0]     ram_waddr;
  logic [ADR_W-1:0]     ram_raddr;
  logic [TASK_BITS-1:0] ram_rdata;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    next_slot = (p == PTR_W'(LEVEL_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [ADR_W-1:0] slot_addr(input logic [LVL_W-1:0] idx,
                                                 input logic [PTR_W-1:0] ptr);
    slot_addr = ADR_W'(idx) * ADR_W'(LEVEL_DEPTH) + ADR_W'(ptr);
  endfunction

  // Clamp the active count, qualify the requested level.
  always_comb begin
    eff      = (int'(active_r) > NUM_LEVELS) ? EFF_W'(NUM_LEVELS) : EFF_W'(active_r);
    level_ok = (req_r != '0) && ({2'b00, req_r} <= eff);
    lv       = level_ok ? LVL_W'({2'b00, req_r} - 6'd1) : '0;
  end

  // Priority encoder: lowest-numbered non-empty active level.
  always_comb begin
    found = 1'b0;
    top   = '0;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (count_r[i] != '0 && i < int'(eff)) begin
        found = 1'b1;
        top   = LVL_W'(i);
      end
    end
  end

  always_comb begin
    lv_full = (count_r[lv] == CNT_W'(LEVEL_DEPTH));
    push_ok = cmd.execute && (mode_r == MODE_PUSH) && level_ok && !lv_full;
    pop_ok  = cmd.execute && (mode_r == MODE_POP) && found;
  end

  always_comb begin
    case (mode_r)
      MODE_PUSH: status_nxt = !level_ok ? ST_BAD : (lv_full ? ST_FULL : ST_OK);
      MODE_POP:  status_nxt = found ? ST_OK : ST_EMPTY;
      default:   status_nxt = level_ok ? ST_OK : ST_BAD;
    endcase
  end

  // Per-level update: advance tail on push, head on pop.
  always_comb begin
    for (int i = 0; i < NUM_LEVELS; i++) begin
      head_nxt[i]  = head_r[i];
      tail_nxt[i]  = tail_r[i];
      count_nxt[i] = count_r[i];
      if (push_ok && lv == LVL_W'(i)) begin
        tail_nxt[i]  = next_slot(tail_r[i]);
        count_nxt[i] = count_r[i] + CNT_W'(1);
      end
      if (pop_ok && top == LVL_W'(i)) begin
        head_nxt[i]  = next_slot(head_r[i]);
        count_nxt[i] = count_r[i] - CNT_W'(1);
      end
    end
  end

  assign ram_we    = push_ok;
  assign ram_waddr = slot_addr(lv, tail_r[lv]);
  assign ram_raddr = slot_addr(top, head_r[top]);

  spmq_ram #(
    .WIDTH (TASK_BITS),
    .DEPTH (MEM_D)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (task_r),
    .re    (cmd.lookup),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= ACTIVE_RESET;
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head_r[i]  <= '0;
        tail_r[i]  <= '0;
        count_r[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        active_r <= cfg_wr_data;
      end
      if (cmd.execute) begin
        for (int i = 0; i < NUM_LEVELS; i++) begin
          head_r[i]  <= head_nxt[i];
          tail_r[i]  <= tail_nxt[i];
          count_r[i] <= count_nxt[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r <= in_mode;
      req_r  <= in_priority_req;
      task_r <= TASK_BITS'(in_task_id);
    end
    if (cmd.execute) begin
      status_r <= status_nxt;
    end
    if (cmd.lookup) begin
      found_r <= found;
      len_r   <= level_ok ? LEN_W'(count_r[lv]) : '0;
    end
    if (cmd.load) begin
      out_head_task_r    <= found_r ? TASK_W'(ram_rdata) : '0;
      out_head_valid_r   <= found_r;
      out_level_length_r <= len_r;
      out_status_r       <= status_r;
    end
  end

  assign out_head_task    = out_head_task_r;
  assign out_head_valid   = out_head_valid_r;
  assign out_all_empty    = !out_head_valid_r;
  assign out_level_length = out_level_length_r;
  assign out_status       = out_status_r;

  for (genvar g = 0; g < NUM_LEVELS; g++) begin : g_chk
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
      count_r[g] <= CNT_W'(LEVEL_DEPTH))
      else $error("level count above depth");
  end

  a_drop_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.execute && status_nxt != ST_OK) |-> !ram_we)
    else $error("store written on a rejected item");

  a_pop_moves_count: assert property (@(posedge clk) disable iff (!rst_n)
    pop_ok |=> count_r[$past(top)] == $past(count_r[top]) - CNT_W'(1))
    else $error("pop did not shrink its level");

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the strict priority multi queue.
// ----------------------------------------------------------------------------
// Runs a short directed table first: empty queue, field extremes, bad
// levels, a full level, hidden levels and active counts of zero and above
// the level count. A long random run follows, split into phases that each
// pick an active_levels setting and a push/pop mix. Every item that
// transfers goes through a local predictor of the per-level FIFOs. Each
// result that transfers is checked field by field against the oldest
// prediction. Both sides idle at random. Two phases hold the result side
// off long enough to back the block up, and one pauses the sender until
// every result has drained.
// ----------------------------------------------------------------------------
module tb;
  import spmq_pkg::*;

  localparam int NUM_LEVELS      = 8;
  localparam int LEVEL_DEPTH     = 16;
  localparam int RESET_CYCLES    = 7;
  localparam int SETTLE_CYCLES   = 8;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int MAX_REPORTS     = 10;
  localparam int RANDOM_PHASES   = 14;
  localparam int PHASE_ITEMS     = 93;

  // Mode 3 is unused by the block and must behave as a query.
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;
  typedef enum int {MIX_BALANCED, MIX_FILL, MIX_DRAIN, MIX_NARROW} op_mix_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [REQ_W-1:0]  req;
    logic [TASK_W-1:0] tid;
  } queue_op_t;

  typedef struct packed {
    logic [TASK_W-1:0]   head_task;
    logic                head_valid;
    logic                all_empty;
    logic [LEN_W-1:0]    level_length;
    logic [STATUS_W-1:0] status;
  } queue_result_t;

  typedef struct {
    row_kind_t           kind;
    queue_op_t           op;
    int                  reps;      // pushes/pops repeated, task id counts up
    logic [ACTIVE_W-1:0] cfg_val;
    bit                  typed;     // expected result written in the row
    queue_result_t       res;
  } dir_row_t;

  // --------------------------------------------------------------------------
  // DUT signals
  // --------------------------------------------------------------------------
  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_wr_en;
  logic [ACTIVE_W-1:0] cfg_wr_data;
  logic                in_valid;
  logic                in_ready;
  logic [MODE_W-1:0]   in_mode;
  logic [REQ_W-1:0]    in_priority_req;
  logic [TASK_W-1:0]   in_task_id;
  logic                out_valid;
  logic                out_ready;
  logic [TASK_W-1:0]   out_head_task;
  logic                out_head_valid;
  logic                out_all_empty;
  logic [LEN_W-1:0]    out_level_length;
  logic [STATUS_W-1:0] out_status;

  strict_priority_multi_queue #(
    .NUM_LEVELS  (NUM_LEVELS),
    .LEVEL_DEPTH (LEVEL_DEPTH),
    .TASK_BITS   (TASK_W)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_priority_req  (in_priority_req),
    .in_task_id       (in_task_id),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_head_task    (out_head_task),
    .out_head_valid   (out_head_valid),
    .out_all_empty    (out_all_empty),
    .out_level_length (out_level_length),
    .out_status       (out_status)
  );

  always #1 clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor state: one circular FIFO per level plus the active count
  // --------------------------------------------------------------------------
  logic [TASK_W-1:0]   pq_store [NUM_LEVELS][LEVEL_DEPTH];
  int                  pq_head  [NUM_LEVELS];
  int                  pq_tail  [NUM_LEVELS];
  int                  pq_count [NUM_LEVELS];
  logic [ACTIVE_W-1:0] pq_active;

  queue_result_t pending_results[$];

  // Run bookkeeping
  int  fail_count   = 0;
  int  ops_sent     = 0;
  int  cfg_writes   = 0;
  int  full_drops   = 0;
  int  empty_pops   = 0;
  int  bad_levels   = 0;
  int  long_holds   = 0;
  int  cycle_count  = 0;
  bit  idle_off     = 1'b0;   // both sides run back to back
  bit  hold_off_req = 1'b0;   // ask the result side for one long stall

  function automatic int live_levels();
    return (pq_active > NUM_LEVELS) ? NUM_LEVELS : int'(pq_active);
  endfunction

  // Most urgent non-empty active level, -1 when every active level is empty.
  function automatic int urgent_level();
    int i;
    for (i = 0; i < live_levels(); i++) begin
      if (pq_count[i] != 0) return i;
    end
    return -1;
  endfunction

  // Apply one operation to the predicted queues and return the result the
  // block must report for it.
  function automatic queue_result_t predict_queue_result(input queue_op_t op);
    queue_result_t r;
    bit            lvl_ok;
    int            lv;
    int            top;
    r      = '0;
    r.status = ST_OK;
    lvl_ok = (op.req >= 1) && (int'(op.req) <= live_levels());
    lv     = lvl_ok ? int'(op.req) - 1 : 0;
    case (op.mode)
      MODE_PUSH: begin
        if (!lvl_ok) begin
          r.status = ST_BAD;
        end else if (pq_count[lv] >= LEVEL_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          pq_store[lv][pq_tail[lv]] = op.tid;
          pq_tail[lv]  = (pq_tail[lv] + 1) % LEVEL_DEPTH;
          pq_count[lv] = pq_count[lv] + 1;
        end
      end
      MODE_POP: begin
        // Pop status ignores the named level.
        top = urgent_level();
        if (top < 0) begin
          r.status = ST_EMPTY;
        end else begin
          pq_head[top]  = (pq_head[top] + 1) % LEVEL_DEPTH;
          pq_count[top] = pq_count[top] - 1;
        end
      end
      default: begin
        if (!lvl_ok) r.status = ST_BAD;
      end
    endcase
    top = urgent_level();
    if (top >= 0) begin
      r.head_task  = pq_store[top][pq_head[top]];
      r.head_valid = 1'b1;
    end
    r.all_empty = (top < 0);
    if (lvl_ok) r.level_length = LEN_W'(pq_count[lv]);
    return r;
  endfunction

  function automatic int draw_gap();
    return idle_off ? 0 : $urandom_range(0, 15);
  endfunction

  // Mostly well-formed traffic on the active levels, with some noise on the
  // level field (zero and levels beyond the active count).
  function automatic queue_op_t random_op(input op_mix_t mix);
    queue_op_t op;
    int        roll;
    int        push_pct;
    int        pop_pct;
    int        span;
    case (mix)
      MIX_FILL:   begin push_pct = 70; pop_pct = 15; end
      MIX_DRAIN:  begin push_pct = 25; pop_pct = 60; end
      MIX_NARROW: begin push_pct = 65; pop_pct = 20; end
      default:    begin push_pct = 45; pop_pct = 35; end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < push_pct)                op.mode = MODE_PUSH;
    else if (roll < push_pct + pop_pct) op.mode = MODE_POP;
    else if (roll < 95)                 op.mode = MODE_QUERY;
    else                                op.mode = MODE_SPARE;
    span = (mix == MIX_NARROW && live_levels() > 2) ? 2 : live_levels();
    if (span == 0 || $urandom_range(0, 99) < 8) op.req = REQ_W'($urandom_range(0, 15));
    else                                        op.req = REQ_W'($urandom_range(1, span));
    op.tid = TASK_W'($urandom());
    return op;
  endfunction

  function automatic dir_row_t row_op(input logic [MODE_W-1:0] mode,
                                      input logic [REQ_W-1:0] req,
                                      input logic [TASK_W-1:0] tid,
                                      input int reps);
    dir_row_t row;
    row = '{kind: ROW_ITEM, op: '{mode, req, tid}, reps: reps, cfg_val: '0,
            typed: 1'b0, res: '0};
    return row;
  endfunction

  function automatic dir_row_t row_known(input logic [MODE_W-1:0] mode,
                                         input logic [REQ_W-1:0] req,
                                         input logic [TASK_W-1:0] tid,
                                         input queue_result_t res);
    dir_row_t row;
    row       = row_op(mode, req, tid, 1);
    row.typed = 1'b1;
    row.res   = res;
    return row;
  endfunction

  function automatic dir_row_t row_cfg(input logic [ACTIVE_W-1:0] v);
    dir_row_t row;
    row = '{kind: ROW_CFG, op: '0, reps: 0, cfg_val: v, typed: 1'b0, res: '0};
    return row;
  endfunction

  // --------------------------------------------------------------------------
  // Input side: one transfer per call, payload held until accepted
  // --------------------------------------------------------------------------
  task automatic send_op(input queue_op_t op, input bit typed,
                         input queue_result_t typed_res);
    int            gap;
    queue_result_t pred;
    gap = draw_gap();
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid        <= 1'b1;
    in_mode         <= op.mode;
    in_priority_req <= op.req;
    in_task_id      <= op.tid;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // Transfer taken at this edge: advance the predictor.
    pred = predict_queue_result(op);
    pending_results.push_back(typed ? typed_res : pred);
    ops_sent++;
    if (pred.status == ST_FULL)  full_drops++;
    if (pred.status == ST_EMPTY) empty_pops++;
    if (pred.status == ST_BAD)   bad_levels++;
  endtask

  // Drop valid and wait until every predicted result has come out, then let
  // the pipeline settle.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register writes happen only with the block idle.
  task automatic write_active_levels(input logic [ACTIVE_W-1:0] v);
    drain_results();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    pq_active = v;
    cfg_writes++;
  endtask

  task automatic report_failure(input string what, input queue_result_t want,
                                input queue_result_t got);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("[%0t] %s: expected head=%h hv=%b empty=%b len=%0d st=%0d",
               $realtime, what, want.head_task, want.head_valid, want.all_empty,
               want.level_length, want.status);
      $display("           got      head=%h hv=%b empty=%b len=%0d st=%0d",
               got.head_task, got.head_valid, got.all_empty, got.level_length,
               got.status);
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stall per result, plus one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int stall;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_off_req) begin
        // Hold off long enough for the block to fill and stall its input.
        hold_off_req = 1'b0;
        long_holds++;
        repeat (HOLD_OFF_CYCLES) begin
          @(negedge clk);
          out_ready <= 1'b0;
        end
      end
      stall = draw_gap();
      repeat (stall) begin
        @(negedge clk);
        out_ready <= 1'b0;
      end
      @(negedge clk);
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Compare every result transfer with the oldest prediction.
  queue_result_t want_res;
  queue_result_t got_res;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      got_res = '{out_head_task, out_head_valid, out_all_empty, out_level_length,
                  out_status};
      if (pending_results.size() == 0) begin
        report_failure("result with nothing pending", '0, got_res);
      end else begin
        want_res = pending_results.pop_front();
        if (got_res.head_task    !== want_res.head_task  ||
            got_res.head_valid   !== want_res.head_valid ||
            got_res.all_empty    !== want_res.all_empty  ||
            got_res.level_length !== want_res.level_length ||
            got_res.status       !== want_res.status) begin
          report_failure("result mismatch", want_res, got_res);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               pending_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    dir_row_t            dir_table[$];
    logic [ACTIVE_W-1:0] phase_cfg [RANDOM_PHASES];
    queue_op_t           op;
    int                  i;
    int                  k;
    int                  ph;
    int                  n;

    rst_n           = 1'b0;
    cfg_wr_en       = 1'b0;
    cfg_wr_data     = ACTIVE_RESET;
    in_valid        = 1'b0;
    in_mode         = MODE_QUERY;
    in_priority_req = '0;
    in_task_id      = '0;

    pq_active = ACTIVE_RESET;
    for (i = 0; i < NUM_LEVELS; i++) begin
      pq_head[i]  = 0;
      pq_tail[i]  = 0;
      pq_count[i] = 0;
    end

    // Directed table. Expected results are written in where they are
    // obvious; the rest come from the predictor.
    dir_table.push_back(row_known(MODE_QUERY, 4'd1, 16'h0000,
                                  '{16'h0000, 1'b0, 1'b1, 5'd0, ST_OK}));
    dir_table.push_back(row_known(MODE_POP, 4'd1, 16'h0000,
                                  '{16'h0000, 1'b0, 1'b1, 5'd0, ST_EMPTY}));
    dir_table.push_back(row_known(MODE_PUSH, 4'd8, 16'hFFFF,
                                  '{16'hFFFF, 1'b1, 1'b0, 5'd1, ST_OK}));
    dir_table.push_back(row_known(MODE_PUSH, 4'd1, 16'h0000,
                                  '{16'h0000, 1'b1, 1'b0, 5'd1, ST_OK}));
    dir_table.push_back(row_known(MODE_PUSH, 4'd0, 16'h1234,
                                  '{16'h0000, 1'b1, 1'b0, 5'd0, ST_BAD}));
    dir_table.push_back(row_known(MODE_PUSH, 4'd9, 16'h4321,
                                  '{16'h0000, 1'b1, 1'b0, 5'd0, ST_BAD}));
    dir_table.push_back(row_op(MODE_PUSH, 4'd15, 16'hA5A5, 1));
    dir_table.push_back(row_op(MODE_SPARE, 4'd8, 16'h5A5A, 1));
    dir_table.push_back(row_op(MODE_POP, 4'd8, 16'h0000, 1));
    dir_table.push_back(row_op(MODE_POP, 4'd3, 16'h0000, 1));
    // Fill level 2, then push once more into the full level.
    dir_table.push_back(row_op(MODE_PUSH, 4'd2, 16'h0100, LEVEL_DEPTH));
    dir_table.push_back(row_known(MODE_PUSH, 4'd2, 16'hDEAD,
                                  '{16'h0100, 1'b1, 1'b0, 5'd16, ST_FULL}));
    // One active level: level 2 stays filled but hidden.
    dir_table.push_back(row_cfg(4'd1));
    dir_table.push_back(row_known(MODE_QUERY, 4'd2, 16'h0000,
                                  '{16'h0000, 1'b0, 1'b1, 5'd0, ST_BAD}));
    dir_table.push_back(row_known(MODE_POP, 4'd1, 16'h0000,
                                  '{16'h0000, 1'b0, 1'b1, 5'd0, ST_EMPTY}));
    dir_table.push_back(row_op(MODE_PUSH, 4'd1, 16'h5555, 1));
    // No active level at all.
    dir_table.push_back(row_cfg(4'd0));
    dir_table.push_back(row_known(MODE_PUSH, 4'd1, 16'h7777,
                                  '{16'h0000, 1'b0, 1'b1, 5'd0, ST_BAD}));
    dir_table.push_back(row_known(MODE_POP, 4'd1, 16'h0000,
                                  '{16'h0000, 1'b0, 1'b1, 5'd0, ST_EMPTY}));
    // Active count above the level count acts as all levels.
    dir_table.push_back(row_cfg(4'd15));
    dir_table.push_back(row_op(MODE_QUERY, 4'd2, 16'h0000, 1));
    dir_table.push_back(row_op(MODE_POP, 4'd2, 16'h0000, LEVEL_DEPTH + 2));
    dir_table.push_back(row_cfg(4'd9));
    dir_table.push_back(row_op(MODE_PUSH, 4'd8, 16'hFFF0, 3));
    dir_table.push_back(row_cfg(ACTIVE_RESET));

    phase_cfg = '{4'd8, 4'd2, 4'd8, 4'd1, 4'd15, 4'd3, 4'd8,
                  4'd0, 4'd5, 4'd8, 4'd12, 4'd4, 4'd7, 4'd8};
    phase_cfg[11] = ACTIVE_W'($urandom_range(0, 15));

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Walk the directed table.
    for (i = 0; i < dir_table.size(); i++) begin
      if (dir_table[i].kind == ROW_CFG) begin
        write_active_levels(dir_table[i].cfg_val);
      end else begin
        for (k = 0; k < dir_table[i].reps; k++) begin
          op     = dir_table[i].op;
          op.tid = op.tid + TASK_W'(k);
          send_op(op, dir_table[i].typed, dir_table[i].res);
        end
      end
    end

    // Random phases: new setting, new traffic mix, idle pattern per phase.
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      write_active_levels(phase_cfg[ph]);
      idle_off = (ph % 5 == 4);
      if (ph == 2 || ph == 9) hold_off_req = 1'b1;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        // Pause the sender halfway through one phase until all results drain.
        if (ph == 6 && n == PHASE_ITEMS / 2) drain_results();
        send_op(random_op(op_mix_t'(ph % 4)), 1'b0, '0);
      end
    end
    idle_off = 1'b0;

    drain_results();

    $display("Sent %0d queue operations over %0d active_levels writes, %0d long output stalls.",
             ops_sent, cfg_writes, long_holds);
    $display("Saw %0d full-level drops, %0d pops on empty, %0d bad-level requests.",
             full_drops, empty_pops, bad_levels);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d failures", fail_count);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/spmq_pkg.sv
rtl/core/spmq_ram.sv
rtl/core/spmq_ctrl.sv
rtl/core/spmq_dp.sv
rtl/core/strict_priority_multi_queue.sv
bench/tb.sv
